FILE: rtl/array_list_engine_macros.svh
// Assertion macros shared by the array list engine RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ARRAY_LIST_ENGINE_MACROS_SVH
`define ARRAY_LIST_ENGINE_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define ALE_ASSERT_HOLDS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("array list engine check failed");

// Consequent must hold in the same cycle as the antecedent.
`define ALE_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("array list engine check failed");

// Consequent must hold in the cycle after the antecedent.
`define ALE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("array list engine check failed");

`endif

FILE: rtl/ale_pkg.sv
// Shared types and constants of the array list engine.
// No dependencies; used by the cell, the top level and the bench.
`timescale 1ns / 1ps

package ale_pkg;

    // Index and count width large enough for the largest supported depth
    localparam int IDX_W = 11;

    typedef enum logic [2:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_POP_BACK   = 3'd1,
        OP_PUSH_FRONT = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_INSERT     = 3'd4,
        OP_ERASE      = 3'd5,
        OP_FIND       = 3'd6
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_BAD_POS   = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    typedef enum logic {
        FSM_IDLE = 1'b0,
        FSM_FIND = 1'b1
    } fsm_t;

    // What every cell does in this cycle
    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_OPEN  = 2'd1,
        CELL_CLOSE = 2'd2,
        CELL_FIND  = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t           kind;
        logic [IDX_W-1:0]   at;
        logic [IDX_W-1:0]   cnt;
    } cell_cmd_t;

endpackage

FILE: rtl/ale_req_if.sv
// Request channel of the array list engine: valid/ready plus operation fields.
// Depends on nothing.
`timescale 1ns / 1ps

interface ale_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         op;
    logic [4:0]         position;
    logic signed [31:0] value;

    modport source (output valid, output op, output position, output value, input ready);
    modport sink   (input valid, input op, input position, input value, output ready);
endinterface

FILE: rtl/ale_rsp_if.sv
// Response channel of the array list engine: valid/ready plus result fields.
// Depends on nothing.
`timescale 1ns / 1ps

interface ale_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [3:0] found_index;
    logic [4:0] list_count;

    modport source (output valid, output status, output found_index, output list_count,
                    input ready);
    modport sink   (input valid, input status, input found_index, input list_count,
                    output ready);
endinterface

FILE: rtl/ale_cell.sv
// One storage cell of the list row: holds one entry and a registered match flag.
// Depends on ale_pkg for the broadcast command type.
`timescale 1ns / 1ps

module ale_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int INDEX      = 0
) (
    input  logic                    clk,
    input  ale_pkg::cell_cmd_t      cmd,
    input  logic [DATA_WIDTH-1:0]   word,
    input  logic [DATA_WIDTH-1:0]   left_entry,
    input  logic [DATA_WIDTH-1:0]   right_entry,
    output logic [DATA_WIDTH-1:0]   entry,
    output logic                    hit
);

    localparam logic [ale_pkg::IDX_W-1:0] IDX = ale_pkg::IDX_W'(INDEX);
    localparam logic [ale_pkg::IDX_W-1:0] IDX_UP = ale_pkg::IDX_W'(INDEX + 1);

    logic [DATA_WIDTH-1:0] entry_reg, entry_next;
    logic                  hit_reg, hit_next;

    // Shift, load or hold depending on where the gap opens or closes; on find, register the match flag
    always_comb
    begin
        entry_next = entry_reg;
        hit_next   = hit_reg;
        case (cmd.kind)
            ale_pkg::CELL_OPEN:
            begin
                if (IDX == cmd.at)
                    entry_next = word;
                else if (IDX > cmd.at && IDX <= cmd.cnt)
                    entry_next = left_entry;
            end
            ale_pkg::CELL_CLOSE:
            begin
                if (IDX >= cmd.at && IDX_UP < cmd.cnt)
                    entry_next = right_entry;
            end
            ale_pkg::CELL_FIND:
            begin
                hit_next = (entry_reg == word) && (IDX < cmd.cnt);
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        hit_reg   <= hit_next;
    end

    assign entry = entry_reg;
    assign hit   = hit_reg;

endmodule

FILE: rtl/array_list_engine.sv
// Array list engine: an ordered list of up to DEPTH words in a row of cells, with a count.
// Push, pop, insert and erase act when a request is taken: the affected cells shift to or from
// their neighbors in the same cycle. For find, the cells compare in parallel into
// registered match flags, then a priority encoder picks the lowest index. A result sits in
// an output register; a new request is taken once that register is empty or being drained
// and no find is in progress. Reset clears the count; the entries themselves are not reset.
// Depends on ale_pkg, ale_req_if, ale_rsp_if, ale_cell and array_list_engine_macros.svh.
`timescale 1ns / 1ps
`include "array_list_engine_macros.svh"

module array_list_engine #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    ale_req_if.sink     req,
    ale_rsp_if.source   rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = ale_pkg::IDX_W;
    localparam logic [IDX_W-1:0] DEPTH_X = IDX_W'(DEPTH);

    // Control state
    ale_pkg::fsm_t          state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   rsp_valid_reg, rsp_valid_next;

    // Result payload
    ale_pkg::status_t       status_reg, status_next;
    logic [3:0]             found_reg, found_next;
    logic [4:0]             lcount_reg, lcount_next;

    logic                   fire;
    logic                   is_find;
    logic                   slot_free;
    logic [IDX_W-1:0]       count_x;
    logic [IDX_W-1:0]       count_x_next;
    logic [IDX_W-1:0]       pos_x;
    ale_pkg::status_t       dec_status;
    ale_pkg::cell_cmd_t     cmd;
    logic [DATA_WIDTH-1:0]  word;
    logic [DATA_WIDTH-1:0]  cell_entry [DEPTH];
    logic [DEPTH-1:0]       hit;
    logic [IDX_W-1:0]       enc_index;
    logic                   enc_any;

    // Request word at the stored width
    generate
        if (DATA_WIDTH <= 32)
        begin : g_word_narrow
            assign word = req.value[DATA_WIDTH-1:0];
        end
        else
        begin : g_word_wide
            assign word = {{(DATA_WIDTH-32){1'b0}}, req.value};
        end
    endgenerate

    assign count_x   = IDX_W'(count_reg);
    assign pos_x     = IDX_W'(req.position);
    assign slot_free = !rsp_valid_reg || rsp.ready;
    assign fire      = req.valid && req.ready;
    assign is_find   = (req.op == ale_pkg::OP_FIND);

    // Operation decode: cell command, status and new count
    always_comb
    begin
        cmd.kind     = ale_pkg::CELL_HOLD;
        cmd.at       = '0;
        cmd.cnt      = count_x;
        dec_status   = ale_pkg::ST_OK;
        count_x_next = count_x;
        unique case (ale_pkg::op_t'(req.op))
            ale_pkg::OP_PUSH_BACK:
            begin
                if (count_x >= DEPTH_X)
                    dec_status = ale_pkg::ST_FULL;
                else
                begin
                    cmd.kind = ale_pkg::CELL_OPEN;
                    cmd.at   = count_x;
                end
            end
            ale_pkg::OP_POP_BACK:
            begin
                if (count_x == '0)
                    dec_status = ale_pkg::ST_EMPTY;
                else
                begin
                    cmd.kind = ale_pkg::CELL_CLOSE;
                    cmd.at   = count_x - IDX_W'(1);
                end
            end
            ale_pkg::OP_PUSH_FRONT:
            begin
                if (count_x >= DEPTH_X)
                    dec_status = ale_pkg::ST_FULL;
                else
                    cmd.kind = ale_pkg::CELL_OPEN;
            end
            ale_pkg::OP_POP_FRONT:
            begin
                if (count_x == '0)
                    dec_status = ale_pkg::ST_EMPTY;
                else
                    cmd.kind = ale_pkg::CELL_CLOSE;
            end
            ale_pkg::OP_INSERT:
            begin
                if (count_x >= DEPTH_X)
                    dec_status = ale_pkg::ST_FULL;
                else if (pos_x > count_x)
                    dec_status = ale_pkg::ST_BAD_POS;
                else
                begin
                    cmd.kind = ale_pkg::CELL_OPEN;
                    cmd.at   = pos_x;
                end
            end
            ale_pkg::OP_ERASE:
            begin
                if (count_x == '0)
                    dec_status = ale_pkg::ST_EMPTY;
                else if (pos_x >= count_x)
                    dec_status = ale_pkg::ST_BAD_POS;
                else
                begin
                    cmd.kind = ale_pkg::CELL_CLOSE;
                    cmd.at   = pos_x;
                end
            end
            ale_pkg::OP_FIND:
            begin
                cmd.kind = ale_pkg::CELL_FIND;
            end
            default:
            begin
                dec_status = ale_pkg::ST_OK;
            end
        endcase
        if (!fire)
            cmd.kind = ale_pkg::CELL_HOLD;
        if (cmd.kind == ale_pkg::CELL_OPEN)
            count_x_next = count_x + IDX_W'(1);
        else if (cmd.kind == ale_pkg::CELL_CLOSE)
            count_x_next = count_x - IDX_W'(1);
    end

    assign count_next = CNT_W'(count_x_next);

    // Row of cells, each wired to its neighbors; the edge cells see zero beyond the row
    generate
        for (genvar i = 0; i < DEPTH; i++)
        begin : g_cell
            logic [DATA_WIDTH-1:0] left_w;
            logic [DATA_WIDTH-1:0] right_w;
            if (i == 0)
            begin : g_left_edge
                assign left_w = '0;
            end
            else
            begin : g_left_link
                assign left_w = cell_entry[i-1];
            end
            if (i == DEPTH - 1)
            begin : g_right_edge
                assign right_w = '0;
            end
            else
            begin : g_right_link
                assign right_w = cell_entry[i+1];
            end
            ale_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .INDEX      (i)
            ) u_cell (
                .clk         (clk),
                .cmd         (cmd),
                .word        (word),
                .left_entry  (left_w),
                .right_entry (right_w),
                .entry       (cell_entry[i]),
                .hit         (hit[i])
            );
        end
    endgenerate

    // Lowest matching index from the registered match flags
    always_comb
    begin
        enc_index = '0;
        enc_any   = 1'b0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                enc_index = IDX_W'(i);
                enc_any   = 1'b1;
            end
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ale_pkg::FSM_IDLE:
            begin
                if (fire && is_find)
                    state_next = ale_pkg::FSM_FIND;
            end
            ale_pkg::FSM_FIND:
            begin
                state_next = ale_pkg::FSM_IDLE;
            end
            default:
            begin
                state_next = ale_pkg::FSM_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        req.ready = 1'b0;
        unique case (state_reg)
            ale_pkg::FSM_IDLE: req.ready = slot_free;
            ale_pkg::FSM_FIND: req.ready = 1'b0;
            default:           req.ready = 1'b0;
        endcase
    end

    // Result register load
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        status_next    = status_reg;
        found_next     = found_reg;
        lcount_next    = lcount_reg;
        if (state_reg == ale_pkg::FSM_FIND)
        begin
            rsp_valid_next = 1'b1;
            status_next    = enc_any ? ale_pkg::ST_OK : ale_pkg::ST_NOT_FOUND;
            found_next     = enc_index[3:0];
            lcount_next    = count_x[4:0];
        end
        else if (fire && !is_find)
        begin
            rsp_valid_next = 1'b1;
            status_next    = dec_status;
            found_next     = '0;
            lcount_next    = count_x_next[4:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ale_pkg::FSM_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        found_reg  <= found_next;
        lcount_reg <= lcount_next;
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.found_index = found_reg;
    assign rsp.list_count  = lcount_reg;

    // Checks
    `ALE_ASSERT_HOLDS(a_count_bound, count_x <= DEPTH_X)
    `ALE_ASSERT_IMPLIES(a_find_slot_free, state_reg == ale_pkg::FSM_FIND, !rsp_valid_reg)
    `ALE_ASSERT_NEXT(a_find_gives_result, state_reg == ale_pkg::FSM_FIND, rsp_valid_reg)
    `ALE_ASSERT_NEXT(a_open_grows, cmd.kind == ale_pkg::CELL_OPEN, count_x == $past(count_x) + IDX_W'(1))

endmodule

FILE: bench/list_engine_checker.sv
// Checker for the array list engine: watches both channels, keeps a shadow copy of the list,
// predicts each reply and compares it field by field. Depends on ale_pkg, ale_req_if, ale_rsp_if.
`timescale 1ns / 1ps

module list_engine_checker #(
    parameter int DEPTH = 16
) (
    input  logic clk,
    input  logic rst_n,
    ale_req_if   req,
    ale_rsp_if   rsp,
    output int   fail_count,
    output int   pending
);

    typedef struct packed {
        ale_pkg::status_t status;
        logic [3:0]       found_index;
        logic [4:0]       list_count;
    } list_outcome_t;

    // Shadow of the list contents, index 0 at the front
    logic [31:0]   shadow_words[$];
    // Predicted replies, oldest first
    list_outcome_t outcome_q[$];

    // Apply one request to the shadow list and return the reply it should give
    function automatic list_outcome_t run_list_op(logic [2:0] op, logic [4:0] pos,
                                                  logic [31:0] word);
        list_outcome_t res;
        logic          hit;
        res.status      = ale_pkg::ST_OK;
        res.found_index = '0;
        hit             = 1'b0;
        case (op) inside
            ale_pkg::OP_PUSH_BACK, ale_pkg::OP_PUSH_FRONT:
                if (shadow_words.size() >= DEPTH)
                    res.status = ale_pkg::ST_FULL;
                else if (op == ale_pkg::OP_PUSH_BACK)
                    shadow_words.push_back(word);
                else
                    shadow_words.push_front(word);
            ale_pkg::OP_POP_BACK:
                if (shadow_words.size() == 0)
                    res.status = ale_pkg::ST_EMPTY;
                else
                    void'(shadow_words.pop_back());
            ale_pkg::OP_POP_FRONT:
                if (shadow_words.size() == 0)
                    res.status = ale_pkg::ST_EMPTY;
                else
                    void'(shadow_words.pop_front());
            ale_pkg::OP_INSERT:
                if (shadow_words.size() >= DEPTH)
                    res.status = ale_pkg::ST_FULL;
                else if (pos > shadow_words.size())
                    res.status = ale_pkg::ST_BAD_POS;
                else
                    shadow_words.insert(pos, word);
            ale_pkg::OP_ERASE:
                if (shadow_words.size() == 0)
                    res.status = ale_pkg::ST_EMPTY;
                else if (pos >= shadow_words.size())
                    res.status = ale_pkg::ST_BAD_POS;
                else
                    shadow_words.delete(pos);
            ale_pkg::OP_FIND:
            begin
                res.status = ale_pkg::ST_NOT_FOUND;
                // lowest matching index wins
                foreach (shadow_words[i])
                begin
                    if (!hit && shadow_words[i] == word)
                    begin
                        hit             = 1'b1;
                        res.status      = ale_pkg::ST_OK;
                        res.found_index = 4'(i);
                    end
                end
            end
            default: ; // unused code: list untouched, plain ok
        endcase
        res.list_count = 5'(shadow_words.size());
        return res;
    endfunction

    // Compare replies first, then record the request taken at the same edge
    always @(posedge clk or negedge rst_n)
    begin : check_p
        list_outcome_t due;
        int            errs;
        errs = 0;
        if (!rst_n)
        begin
            shadow_words.delete();
            outcome_q.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (outcome_q.size() == 0)
                begin
                    $error("reply with no request outstanding: status %0d index %0d count %0d",
                           rsp.status, rsp.found_index, rsp.list_count);
                    errs = errs + 1;
                end
                else
                begin
                    due = outcome_q.pop_front();
                    if (rsp.status !== due.status)
                    begin
                        $error("status: expected %0d, got %0d", due.status, rsp.status);
                        errs = errs + 1;
                    end
                    if (rsp.found_index !== due.found_index)
                    begin
                        $error("found_index: expected %0d, got %0d",
                               due.found_index, rsp.found_index);
                        errs = errs + 1;
                    end
                    if (rsp.list_count !== due.list_count)
                    begin
                        $error("list_count: expected %0d, got %0d",
                               due.list_count, rsp.list_count);
                        errs = errs + 1;
                    end
                end
            end
            if (req.valid && req.ready)
                outcome_q.push_back(run_list_op(req.op, req.position, req.value));
            pending    <= outcome_q.size();
            fail_count <= fail_count + errs;
        end
    end

endmodule

FILE: bench/tb_top.sv
// Top of the array list engine bench: clock, reset, request and reply traffic, verdict.
// Depends on ale_pkg, ale_req_if, ale_rsp_if, array_list_engine and list_engine_checker.
`timescale 1ns / 1ps

module tb_top;

    localparam int         DEPTH        = 16;
    localparam logic [2:0] OP_UNUSED    = 3'd7;
    localparam int         MAX_IDLE     = 5;
    localparam int         HOLD_CYCLES  = 60;
    localparam int         SEGMENTS     = 20;
    localparam int         SEG_ITEMS    = 50;
    localparam int         SETTLE_CYCLES = 20;
    localparam int         CYCLE_LIMIT  = 200000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   cycle_cnt = 0;
    bit   quiet;        // no idling on either side
    bit   hold_replies; // ask the reply side for one long stall

    ale_req_if req_ch();
    ale_rsp_if rsp_ch();

    array_list_engine #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (32)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    list_engine_checker #(
        .DEPTH (DEPTH)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Offer one request after a random gap (none when quiet) and wait until it is taken
    task automatic send_req(input logic [2:0] op, input logic [4:0] pos,
                            input logic [31:0] word);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.op       <= op;
        req_ch.position <= pos;
        req_ch.value    <= word;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
    endtask

    // Stop offering until every reply is back
    task automatic drain_replies();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Mix of operations; grow_pct tilts adds against removals
    function automatic logic [2:0] pick_op(int grow_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return OP_UNUSED;
        if (r < 28)
            return ale_pkg::OP_FIND;
        if ($urandom_range(0, 99) < grow_pct)
        begin
            case ($urandom_range(0, 2))
                0:       return ale_pkg::OP_PUSH_BACK;
                1:       return ale_pkg::OP_PUSH_FRONT;
                default: return ale_pkg::OP_INSERT;
            endcase
        end
        case ($urandom_range(0, 2))
            0:       return ale_pkg::OP_POP_BACK;
            1:       return ale_pkg::OP_POP_FRONT;
            default: return ale_pkg::OP_ERASE;
        endcase
    endfunction

    // Mostly small positions, sometimes the whole field
    function automatic logic [4:0] pick_pos();
        if ($urandom_range(0, 9) == 0)
            return 5'($urandom_range(0, 31));
        return 5'($urandom_range(0, $urandom_range(0, 16)));
    endfunction

    // A small pool keeps finds hitting and makes duplicates
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'h0000_0001;
            5:       return 32'h5A5A_A5A5;
            default: return $urandom;
        endcase
    endfunction

    // Reply side: random stalls, one long hold on request
    initial
    begin
        int stall;
        rsp_ch.ready = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_replies)
            begin
                stall        = HOLD_CYCLES;
                hold_replies = 1'b0;
            end
            else
                stall = quiet ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid) @(posedge clk);
        end
    end

    // Request side and verdict
    initial
    begin
        int grow_pct;
        rst_n           = 1'b0;
        quiet           = 1'b0;
        hold_replies    = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.op       = ale_pkg::OP_PUSH_BACK;
        req_ch.position = '0;
        req_ch.value    = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Empty list: ignored code, removals, find, insert past the end
        send_req(OP_UNUSED, 5'd0, 32'h0);
        send_req(ale_pkg::OP_POP_BACK, 5'd0, 32'h0);
        send_req(ale_pkg::OP_POP_FRONT, 5'd0, 32'h0);
        send_req(ale_pkg::OP_ERASE, 5'd0, 32'h0);
        send_req(ale_pkg::OP_FIND, 5'd0, 32'h0);
        send_req(ale_pkg::OP_INSERT, 5'd1, 32'h5);
        // Extremes of the value field, insert at both ends
        send_req(ale_pkg::OP_INSERT, 5'd0, 32'h8000_0000);
        send_req(ale_pkg::OP_PUSH_BACK, 5'd0, 32'h7FFF_FFFF);
        send_req(ale_pkg::OP_PUSH_FRONT, 5'd0, 32'hFFFF_FFFF);
        send_req(ale_pkg::OP_INSERT, 5'd3, 32'h0);
        send_req(ale_pkg::OP_FIND, 5'd0, 32'h7FFF_FFFF);
        // Positions at and past the end
        send_req(ale_pkg::OP_ERASE, 5'd4, 32'h0);
        send_req(ale_pkg::OP_ERASE, 5'd31, 32'h0);
        send_req(ale_pkg::OP_INSERT, 5'd31, 32'h0);
        // Fill to capacity, then hit the full cases
        for (int i = 4; i < DEPTH; i++)
            send_req(ale_pkg::OP_PUSH_BACK, 5'd0, 32'(i));
        send_req(ale_pkg::OP_FIND, 5'd0, 32'(DEPTH - 1));
        send_req(ale_pkg::OP_PUSH_BACK, 5'd0, 32'h1);
        send_req(ale_pkg::OP_PUSH_FRONT, 5'd0, 32'h1);
        send_req(ale_pkg::OP_INSERT, 5'd0, 32'h1);
        send_req(ale_pkg::OP_ERASE, 5'd15, 32'h0);
        send_req(ale_pkg::OP_ERASE, 5'd7, 32'h0);
        drain_replies();

        // Random traffic in segments that fill, empty or churn the list
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            quiet = (seg % 5 == 2);
            if (seg == 4)
                hold_replies = 1'b1;
            if (seg == 9 || seg == 15)
                drain_replies();
            case (seg % 3)
                0:       grow_pct = 85;
                1:       grow_pct = 15;
                default: grow_pct = 50;
            endcase
            for (int n = 0; n < SEG_ITEMS; n++)
                send_req(pick_op(grow_pct), pick_pos(), pick_word());
        end

        drain_replies();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
